/* hdl/line_point_generator_assert.svh */
// assertion macros for the line point generator
`ifndef LINE_POINT_GENERATOR_ASSERT_SVH
`define LINE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define LPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line point generator check failed");

// next-cycle implication, disabled while reset is held
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line point generator check failed");

`endif

/* hdl/lpg_pkg.sv */
`default_nettype none

package lpg_pkg;

    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int COORD_W             = 16;
    localparam int PIX_W               = 6;
    localparam int CFG_IDX_W           = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [PIX_W-1:0] DIM_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SETUP,
        ST_LINE,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             last_point;
    } t_out_word;

endpackage

`default_nettype wire

/* hdl/line_point_generator.sv */
// Line point generator. Each input word carries two endpoints in signed Q1.14
// normalized coordinates; they are mapped to pixels on a screen of
// screen_width by screen_height (registers 0 and 1, reset 32), ordered so x
// rises, and the line is walked one point per output word, ending with the
// target endpoint flagged by last_point. A line of n = max(dx, dy) steps gives
// n + 1 output words. One shared multiplier maps the four coordinates in turn
// in ST_MAP, the ST_SETUP state follows, then one shared add and compare unit
// walks the line at one point per cycle while the output is not stalled. The
// input is stalled until the last point is loaded into the output register;
// configuration writes are always taken and belong to idle times.
`default_nettype none

`include "line_point_generator_assert.svh"

module line_point_generator #(
    parameter int COORD_FRAC_BITS = lpg_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire lpg_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output lpg_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lpg_pkg::PIX_W-1:0]         i_cfg_data
);

    localparam int PW = lpg_pkg::PIX_W;

    lpg_pkg::t_state    r_state, n_state;
    lpg_pkg::t_in_word  r_in;
    lpg_pkg::t_out_word r_out_word, n_out_word;
    logic               r_out_valid;

    logic [PW-1:0] r_width, r_height;
    logic [1:0]    r_map_idx;
    logic [PW-1:0] r_map [4];

    logic [PW-1:0] r_cur_x, r_cur_y, r_tx, r_ty;
    logic [PW-1:0] r_rem, r_cnt, r_dlong, r_dshort;
    logic          r_xmaj, r_ydn;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_load;
    logic signed [lpg_pkg::COORD_W-1:0] w_coord;
    logic [PW-1:0]               w_dim;
    logic [PW-1:0]               w_pixel;

    logic          w_swap, w_ydn, w_xmaj;
    logic [PW-1:0] w_ox, w_oy, w_tx, w_ty, w_dx, w_dy, w_long, w_short;
    logic [PW:0]   w_sum;
    logic          w_carry;
    logic [PW-1:0] w_rem;

    // coordinate mapping, one coordinate per cycle
    always_comb begin
        case (r_map_idx)
            2'd0: begin
                w_coord = r_in.start_x;
                w_dim   = r_width;
            end
            2'd1: begin
                w_coord = r_in.start_y;
                w_dim   = r_height;
            end
            2'd2: begin
                w_coord = r_in.end_x;
                w_dim   = r_width;
            end
            default: begin
                w_coord = r_in.end_y;
                w_dim   = r_height;
            end
        endcase
    end

    lpg_coord_map #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_map (
        .i_coord (w_coord),
        .i_dim   (w_dim),
        .o_pixel (w_pixel)
    );

    // setup: order endpoints and derive step terms
    assign w_swap  = r_map[0] > r_map[2];
    assign w_ox    = w_swap ? r_map[2] : r_map[0];
    assign w_oy    = w_swap ? r_map[3] : r_map[1];
    assign w_tx    = w_swap ? r_map[0] : r_map[2];
    assign w_ty    = w_swap ? r_map[1] : r_map[3];
    assign w_dx    = w_tx - w_ox;
    assign w_ydn   = !(w_oy < w_ty);
    assign w_dy    = w_ydn ? (w_oy - w_ty) : (w_ty - w_oy);
    assign w_xmaj  = w_dx > w_dy;
    assign w_long  = w_xmaj ? w_dx : w_dy;
    assign w_short = w_xmaj ? w_dy : w_dx;

    // shared add and compare unit for the minor axis
    assign w_sum   = {1'b0, r_rem} + {1'b0, r_dshort};
    assign w_carry = w_sum >= {1'b0, r_dlong};
    assign w_rem   = w_carry ? PW'(w_sum - {1'b0, r_dlong}) : w_sum[PW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpg_pkg::ST_IDLE: begin
                if (w_accept) n_state = lpg_pkg::ST_MAP;
            end
            lpg_pkg::ST_MAP: begin
                if (r_map_idx == 2'd3) n_state = lpg_pkg::ST_SETUP;
            end
            lpg_pkg::ST_SETUP: begin
                n_state = (w_long == '0) ? lpg_pkg::ST_LAST : lpg_pkg::ST_LINE;
            end
            lpg_pkg::ST_LINE: begin
                if (w_load && r_cnt == PW'(1)) n_state = lpg_pkg::ST_LAST;
            end
            lpg_pkg::ST_LAST: begin
                if (w_load) n_state = lpg_pkg::ST_IDLE;
            end
            default: n_state = lpg_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = (r_state != lpg_pkg::ST_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_load     = 1'b0;
        n_out_word = r_out_word;
        case (r_state)
            lpg_pkg::ST_LINE: begin
                w_load     = w_out_free;
                n_out_word = '{pixel_x: r_cur_x, pixel_y: r_cur_y, last_point: 1'b0};
            end
            lpg_pkg::ST_LAST: begin
                w_load     = w_out_free;
                n_out_word = '{pixel_x: r_tx, pixel_y: r_ty, last_point: 1'b1};
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_map_idx   <= '0;
            r_cnt       <= '0;
            r_width     <= lpg_pkg::DIM_RESET;
            r_height    <= lpg_pkg::DIM_RESET;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_map_idx <= '0;
            end else if (r_state == lpg_pkg::ST_MAP) begin
                r_map_idx <= r_map_idx + 2'd1;
            end
            if (r_state == lpg_pkg::ST_SETUP) begin
                r_cnt <= w_long;
            end else if (r_state == lpg_pkg::ST_LINE && w_load) begin
                r_cnt <= r_cnt - PW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lpg_pkg::REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    lpg_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_word;
        end
        if (r_state == lpg_pkg::ST_MAP) begin
            r_map[r_map_idx] <= w_pixel;
        end
        if (w_load) begin
            r_out_word <= n_out_word;
        end
        if (r_state == lpg_pkg::ST_SETUP) begin
            r_cur_x  <= w_ox;
            r_cur_y  <= w_oy;
            r_tx     <= w_tx;
            r_ty     <= w_ty;
            r_rem    <= '0;
            r_dlong  <= w_long;
            r_dshort <= w_short;
            r_xmaj   <= w_xmaj;
            r_ydn    <= w_ydn;
        end else if (r_state == lpg_pkg::ST_LINE && w_load) begin
            r_rem <= w_rem;
            if (r_xmaj) begin
                r_cur_x <= r_cur_x + PW'(1);
                if (w_carry) begin
                    r_cur_y <= r_ydn ? (r_cur_y - PW'(1)) : (r_cur_y + PW'(1));
                end
            end else begin
                r_cur_y <= r_ydn ? (r_cur_y - PW'(1)) : (r_cur_y + PW'(1));
                if (w_carry) begin
                    r_cur_x <= r_cur_x + PW'(1);
                end
            end
        end
    end

    // checks
    `LPG_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n,
        w_load && n_out_word.last_point, r_state == lpg_pkg::ST_IDLE)
    `LPG_ASSERT_NOW(a_rem_below_long, i_clk, i_rst_n,
        r_state == lpg_pkg::ST_LINE, (r_rem < r_dlong) && (r_cnt != '0))
    `LPG_ASSERT_NOW(a_busy_no_accept, i_clk, i_rst_n,
        r_state != lpg_pkg::ST_IDLE, !w_accept)

endmodule

`default_nettype wire

/* hdl/lpg_coord_map.sv */
`default_nettype none

module lpg_coord_map #(
    parameter int COORD_FRAC_BITS = lpg_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic signed [lpg_pkg::COORD_W-1:0] i_coord,
    input  wire logic        [lpg_pkg::PIX_W-1:0]   i_dim,
    output logic             [lpg_pkg::PIX_W-1:0]   o_pixel
);

    localparam int SUM_W  = ((COORD_FRAC_BITS + 2) > (lpg_pkg::COORD_W + 1))
                            ? (COORD_FRAC_BITS + 2) : (lpg_pkg::COORD_W + 1);
    localparam int PROD_W = SUM_W + lpg_pkg::PIX_W + 1;
    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(2 ** COORD_FRAC_BITS);

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shift;
    logic                     w_big;

    // (p + 1) * dim / 2, floored
    assign w_sum   = SUM_W'(i_coord) + ONE_Q;
    assign w_prod  = PROD_W'(w_sum) * PROD_W'($signed({1'b0, i_dim}));
    assign w_shift = w_prod >>> (COORD_FRAC_BITS + 1);
    assign w_big   = |w_shift[PROD_W-1:lpg_pkg::PIX_W];

    always_comb begin
        if (w_prod <= 0) begin
            o_pixel = '0;
        end else if (w_big) begin
            o_pixel = '1;
        end else begin
            o_pixel = w_shift[lpg_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* dv/lpg_checker.sv */
`timescale 1ns / 100ps

module lpg_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  lpg_pkg::t_in_word             i_in_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  lpg_pkg::t_out_word            i_out_word,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpg_pkg::PIX_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int FRAC       = lpg_pkg::COORD_FRAC_BITS_DEF;
    localparam int PW         = lpg_pkg::PIX_W;
    localparam int PIX_MAX    = (1 << PW) - 1;
    localparam int REPORT_CAP = 10;

    logic [PW-1:0]      screen_w = lpg_pkg::DIM_RESET;
    logic [PW-1:0]      screen_h = lpg_pkg::DIM_RESET;
    lpg_pkg::t_out_word line_points[$];
    int                 mismatches = 0;

    function automatic int to_pixel(input logic signed [lpg_pkg::COORD_W-1:0] coord,
                                    input logic [PW-1:0] dim);
        int scaled;
        int px;
        scaled = (int'(coord) + (1 << FRAC)) * int'(dim);
        if (scaled <= 0) begin
            return 0;
        end
        px = scaled >>> (FRAC + 1);
        return (px > PIX_MAX) ? PIX_MAX : px;
    endfunction

    function automatic lpg_pkg::t_out_word make_point(input int x, input int y,
                                                      input logic last);
        lpg_pkg::t_out_word pt;
        pt.pixel_x    = x[PW-1:0];
        pt.pixel_y    = y[PW-1:0];
        pt.last_point = last;
        return pt;
    endfunction

    function automatic void add_point(input lpg_pkg::t_out_word pt);
        line_points.insert(line_points.size(), pt);
    endfunction

    task automatic rasterize(input lpg_pkg::t_in_word w);
        int ox, oy, tx, ty, dx, dy, dir, tmp, k;
        ox = to_pixel(w.start_x, screen_w);
        oy = to_pixel(w.start_y, screen_h);
        tx = to_pixel(w.end_x, screen_w);
        ty = to_pixel(w.end_y, screen_h);
        if (ox > tx) begin
            tmp = ox; ox = tx; tx = tmp;
            tmp = oy; oy = ty; ty = tmp;
        end
        dx  = tx - ox;
        dy  = (ty > oy) ? ty - oy : oy - ty;
        dir = (oy < ty) ? 1 : -1;
        // x-major walk, else y-major walk toward the target
        if (dx > dy) begin
            for (k = 0; k < dx; k++) begin
                add_point(make_point(ox + k, oy + dir * ((k * dy) / dx), 1'b0));
            end
        end else if (dy > 0) begin
            for (k = 0; k < dy; k++) begin
                add_point(make_point(ox + (k * dx) / dy, oy + dir * k, 1'b0));
            end
        end
        add_point(make_point(tx, ty, 1'b1));
    endtask

    always @(posedge i_clk) begin : scoreboard
        lpg_pkg::t_out_word want;
        if (!i_rst_n) begin
            line_points.delete();
            screen_w   = lpg_pkg::DIM_RESET;
            screen_h   = lpg_pkg::DIM_RESET;
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lpg_pkg::REG_SCREEN_WIDTH: begin
                        screen_w = i_cfg_data;
                    end
                    lpg_pkg::REG_SCREEN_HEIGHT: begin
                        screen_h = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            // pop before push: a point never belongs to a word taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (line_points.size() == 0) begin
                    if (mismatches < REPORT_CAP) begin
                        $display("unexpected point: got x=%0d y=%0d last=%0d",
                                 i_out_word.pixel_x, i_out_word.pixel_y,
                                 i_out_word.last_point);
                    end
                    mismatches++;
                end else begin
                    want = line_points.pop_front();
                    if (i_out_word.pixel_x !== want.pixel_x ||
                        i_out_word.pixel_y !== want.pixel_y ||
                        i_out_word.last_point !== want.last_point) begin
                        if (mismatches < REPORT_CAP) begin
                            $display("point mismatch: exp %0d,%0d,%0d got %0d,%0d,%0d",
                                     want.pixel_x, want.pixel_y, want.last_point,
                                     i_out_word.pixel_x, i_out_word.pixel_y,
                                     i_out_word.last_point);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rasterize(i_in_word);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= line_points.size();
    end

endmodule

/* dv/tb_line_point_generator.sv */
`timescale 1ns / 100ps

module tb_line_point_generator;

    localparam int CW           = lpg_pkg::COORD_W;
    localparam int PW           = lpg_pkg::PIX_W;
    localparam int IW           = lpg_pkg::CFG_IDX_W;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_LINES  = 52;
    localparam int SETTLE       = 16;
    localparam logic [IW-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [IW-1:0] REG_UNUSED_HI = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    lpg_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lpg_pkg::t_out_word out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IW-1:0]      cfg_index = lpg_pkg::REG_SCREEN_WIDTH;
    logic [PW-1:0]      cfg_data  = lpg_pkg::DIM_RESET;
    int                 fail_count;
    int                 pending;
    bit                 in_quiet  = 1'b0;
    bit                 out_quiet = 1'b0;
    int                 stall_left = 0;
    int                 quiet_left = 0;
    int                 cycles = 0;

    line_point_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lpg_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk) begin : stall_gen
        int gap;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            quiet_left <= 0;
        end else begin
            if (quiet_left == 0) begin
                quiet_left <= 300;
                out_quiet  <= ($urandom_range(0, 3) == 0);
            end else begin
                quiet_left <= quiet_left - 1;
            end
            if (out_quiet) begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else begin
                gap = idle_gap();
                out_stall  <= (gap != 0);
                stall_left <= (gap == 0) ? 0 : gap - 1;
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return -16'sd16384;
        end else if (r < 16) begin
            return 16'sd16384;
        end else if (r < 26) begin
            return CW'($urandom());
        end
        return CW'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [PW-1:0] rand_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return PW'(1);
        end else if (r == 2) begin
            return '1;
        end
        return PW'($urandom_range(1, 63));
    endfunction

    function automatic lpg_pkg::t_in_word line_word(input int sx, input int sy, input int ex,
                                                    input int ey);
        lpg_pkg::t_in_word w;
        w.start_x = sx[CW-1:0];
        w.start_y = sy[CW-1:0];
        w.end_x   = ex[CW-1:0];
        w.end_y   = ey[CW-1:0];
        return w;
    endfunction

    // called at a rising edge; leaves valid high after the accepting edge
    task automatic push_line(input lpg_pkg::t_in_word w);
        int gap;
        gap = in_quiet ? 0 : idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic push_random_line();
        push_line(line_word(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves valid high; program_screen lowers it once at the end
    task automatic write_reg(input logic [IW-1:0] idx, input logic [PW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_screen(input logic [PW-1:0] w, input logic [PW-1:0] h);
        write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  PW'($urandom()));
        write_reg(lpg_pkg::REG_SCREEN_WIDTH, w);
        write_reg(lpg_pkg::REG_SCREEN_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        logic [PW-1:0] dim_w, dim_h;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset screen size
        push_line(line_word(-16384, -16384, -16384, -16384));
        push_line(line_word(16384, 16384, 16384, 16384));
        push_line(line_word(-16384, -16384, 16384, 16384));
        push_line(line_word(16384, 16384, -16384, -16384));
        push_line(line_word(-16384, 0, 16384, 0));
        push_line(line_word(0, -16384, 0, 16384));
        push_line(line_word(0, 16384, 0, -16384));
        push_line(line_word(-16384, -16384, 16384, -8192));
        push_line(line_word(16384, -16384, -16384, 8192));
        push_line(line_word(-32768, -32768, -20000, 32767));
        push_line(line_word(8192, -16384, -8192, 16384));
        push_line(line_word(100, 200, 300, 400));
        wait_drain();

        // largest screen, saturation high
        program_screen('1, '1);
        push_line(line_word(32767, 32767, -32768, -32768));
        push_line(line_word(32767, -32768, -32768, 32767));
        push_line(line_word(-16384, 16384, 16384, -16384));
        wait_drain();

        // zero screen size
        program_screen('0, '0);
        push_line(line_word(-16384, 16384, 16384, -16384));
        push_line(line_word(32767, -32768, 0, 8000));
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    dim_w = PW'(1);
                    dim_h = PW'(1);
                end
                1: begin
                    dim_w = '0;
                    dim_h = '1;
                end
                2: begin
                    dim_w = '1;
                    dim_h = PW'(1);
                end
                default: begin
                    dim_w = rand_dim();
                    dim_h = rand_dim();
                end
            endcase
            program_screen(dim_w, dim_h);
            for (int n = 0; n < PHASE_LINES; n++) begin
                if (n % 16 == 0) begin
                    in_quiet = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_drain();
                end
                push_random_line();
            end
            wait_drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
